// ===== rtl/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gtrwp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtrwp_pkg
// shared types and codes of the graphics tag register write parser
// ----------------------------------------------------------------------------
package gtrwp_pkg;

    localparam int WORD_W = 64;
    localparam int ADDR_W = 8;
    localparam int TAG_W = 8;
    localparam int LOOP_W = 15;
    localparam int SLOT_W = 4;
    localparam int KIND_W = 2;
    localparam int LIMIT_W = 9;
    localparam int TDATA_W = 104;

    localparam logic [LIMIT_W-1:0] TAG_LIMIT_RESET = 9'd256;

    // register index on the config port
    localparam logic REG_TAG_LIMIT = 1'b0;

    // source kinds
    localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADDR_DATA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RLIST = 2'd2;

    // tag formats
    localparam logic [1:0] FMT_PACKED = 2'd0;
    localparam logic [1:0] FMT_RLIST = 2'd1;
    localparam logic [1:0] FMT_IMAGE = 2'd2;

    localparam logic [3:0] DESC_ADDR_DATA = 4'hE;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] value;
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
        logic [LOOP_W-1:0] loop;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

// ===== rtl/gif_tag_register_write_parser_core.sv =====
// ----------------------------------------------------------------------------
// gif_tag_register_write_parser_core
// decodes graphics tag packets into a stream of register writes
// ----------------------------------------------------------------------------
// channel  direction  handshake                  contents
// s_*      in         s_tvalid / s_tready        packet doubleword, tlast ends packet
// m_*      out        m_tvalid / m_tready        one register write, kind in tuser
// apb      in         psel/penable, pready = 1   tag_limit at address 0
//
// one doubleword is accepted per cycle while s_tready is high; each write
// is registered into a two-entry result queue feeding m_*, which sets the
// stall behavior: s_tready drops only while both queue entries are occupied.
// reset clears all parse state and sets tag_limit to 256.
// ----------------------------------------------------------------------------
module gif_tag_register_write_parser_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gtrwp_pkg::WORD_W-1:0]  s_tdata,   // word
    input  logic                          s_tlast,   // last_word
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // reg_addr, reg_value, tag_number, loop_number, slot_number, zero pad
    output logic [gtrwp_pkg::TDATA_W-1:0] m_tdata,
    output logic [gtrwp_pkg::KIND_W-1:0]  m_tuser,   // source_kind
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gtrwp_pkg::*;

    logic [LIMIT_W-1:0] tag_limit_reg, tag_limit_next;
    logic               accept;
    logic               res_valid;
    result_t            res;
    logic               buf_full;
    result_t            out_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TAG_LIMIT) ? {23'd0, tag_limit_reg} : 32'd0;

    always_comb
    begin
        tag_limit_next = tag_limit_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_TAG_LIMIT))
            tag_limit_next = pwdata[LIMIT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_limit_reg <= TAG_LIMIT_RESET;
        else
            tag_limit_reg <= tag_limit_next;
    end

    assign s_tready = !buf_full;
    assign accept   = s_tvalid && s_tready;

    gtrwp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .word      (s_tdata),
        .last_word (s_tlast),
        .tag_limit (tag_limit_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    gtrwp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .pop       (m_tvalid && m_tready),
        .full      (buf_full),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = {5'd0, out_data.slot, out_data.loop, out_data.tag,
                      out_data.value, out_data.addr};
    assign m_tuser = out_data.kind;

endmodule

// ===== rtl/gtrwp_parser.sv =====
// ----------------------------------------------------------------------------
// gtrwp_parser
// tag decode and per-doubleword phase tracking, one item per cycle while accept is high
// ----------------------------------------------------------------------------
module gtrwp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [gtrwp_pkg::WORD_W-1:0]  word,
    input  logic                          last_word,
    input  logic [gtrwp_pkg::LIMIT_W-1:0] tag_limit,
    output logic                          res_valid,
    output gtrwp_pkg::result_t            res
);
    import gtrwp_pkg::*;

    typedef enum logic [7:0] {
        PH_TAG_LO = 8'b0000_0001,
        PH_TAG_HI = 8'b0000_0010,
        PH_PK_LO  = 8'b0000_0100,
        PH_PK_HI  = 8'b0000_1000,
        PH_RLIST  = 8'b0001_0000,
        PH_PAD    = 8'b0010_0000,
        PH_SKIP   = 8'b0100_0000,
        PH_STOP   = 8'b1000_0000
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [LOOP_W-1:0]   loops_total_reg, loops_total_next;
    logic [LOOP_W-1:0]   loop_count_reg, loop_count_next;
    logic [4:0]          regs_per_loop_reg, regs_per_loop_next;
    logic [SLOT_W-1:0]   slot_count_reg, slot_count_next;
    logic [WORD_W-1:0]   descriptors_reg, descriptors_next;
    logic [WORD_W-1:0]   held_low_reg, held_low_next;
    logic [LIMIT_W-1:0]  tags_seen_reg, tags_seen_next;
    logic [15:0]         skip_left_reg, skip_left_next;
    // only the fields of the tag low word that are used later
    logic [LOOP_W-1:0]   hold_loops_reg, hold_loops_next;
    logic [1:0]          hold_fmt_reg, hold_fmt_next;
    logic [3:0]          hold_nreg_reg, hold_nreg_next;

    logic [3:0]          desc_sel;
    logic [4:0]          slot_inc;
    logic [LOOP_W-1:0]   loop_inc;
    logic                slot_wrap;
    logic                loops_done;
    logic [SLOT_W-1:0]   slot_adv;
    logic [LOOP_W-1:0]   loop_adv;
    logic [15:0]         skip_dec;

    assign desc_sel   = descriptors_reg[{slot_count_reg, 2'b00} +: 4];
    assign slot_inc   = {1'b0, slot_count_reg} + 5'd1;
    assign loop_inc   = loop_count_reg + 15'd1;
    assign slot_wrap  = slot_inc >= regs_per_loop_reg;
    assign loops_done = slot_wrap && (loop_inc >= loops_total_reg);
    assign slot_adv   = slot_wrap ? '0 : slot_inc[SLOT_W-1:0];
    assign loop_adv   = slot_wrap ? loop_inc : loop_count_reg;
    assign skip_dec   = skip_left_reg - 16'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        loops_total_next   = loops_total_reg;
        loop_count_next    = loop_count_reg;
        regs_per_loop_next = regs_per_loop_reg;
        slot_count_next    = slot_count_reg;
        descriptors_next   = descriptors_reg;
        held_low_next      = held_low_reg;
        tags_seen_next     = tags_seen_reg;
        skip_left_next     = skip_left_reg;
        hold_loops_next    = hold_loops_reg;
        hold_fmt_next      = hold_fmt_reg;
        hold_nreg_next     = hold_nreg_reg;

        res_valid = 1'b0;
        res.addr  = {4'd0, desc_sel};
        res.value = word;
        res.kind  = KIND_DIRECT;
        res.tag   = tags_seen_reg[TAG_W-1:0] - 8'd1;
        res.loop  = loop_count_reg;
        res.slot  = slot_count_reg;

        unique case (phase_reg)
            PH_TAG_LO:
            begin
                if (tags_seen_reg >= tag_limit)
                begin
                    phase_next = PH_STOP;
                end
                else
                begin
                    hold_loops_next = word[14:0];
                    hold_fmt_next   = word[59:58];
                    hold_nreg_next  = word[63:60];
                    phase_next      = PH_TAG_HI;
                end
            end
            PH_TAG_HI:
            begin
                descriptors_next   = word;
                loops_total_next   = hold_loops_reg;
                regs_per_loop_next = (hold_nreg_reg == 4'd0) ? 5'd16 : {1'b0, hold_nreg_reg};
                loop_count_next    = '0;
                slot_count_next    = '0;
                tags_seen_next     = tags_seen_reg + 9'd1;
                skip_left_next     = {hold_loops_reg, 1'b0};
                priority if (hold_fmt_reg == FMT_PACKED)
                    phase_next = (hold_loops_reg == '0) ? PH_TAG_LO : PH_PK_LO;
                else if (hold_fmt_reg == FMT_RLIST)
                    phase_next = (hold_loops_reg == '0) ? PH_TAG_LO : PH_RLIST;
                else if (hold_fmt_reg == FMT_IMAGE)
                    phase_next = (hold_loops_reg == '0) ? PH_TAG_LO : PH_SKIP;
                else
                    phase_next = PH_STOP;
            end
            PH_PK_LO:
            begin
                held_low_next = word;
                phase_next    = PH_PK_HI;
            end
            PH_PK_HI:
            begin
                res_valid = 1'b1;
                res.value = held_low_reg;
                if (desc_sel == DESC_ADDR_DATA)
                begin
                    res.addr = word[7:0];
                    res.kind = KIND_ADDR_DATA;
                end
                slot_count_next = slot_adv;
                loop_count_next = loop_adv;
                phase_next      = loops_done ? PH_TAG_LO : PH_PK_LO;
            end
            PH_RLIST:
            begin
                res_valid       = 1'b1;
                res.kind        = KIND_RLIST;
                slot_count_next = slot_adv;
                loop_count_next = loop_adv;
                if (loops_done)
                begin
                    // odd value count leaves one pad doubleword
                    phase_next = (loops_total_reg[0] && regs_per_loop_reg[0]) ?
                                 PH_PAD : PH_TAG_LO;
                end
            end
            PH_PAD:
            begin
                phase_next = PH_TAG_LO;
            end
            PH_SKIP:
            begin
                skip_left_next = skip_dec;
                if (skip_dec == '0)
                    phase_next = PH_TAG_LO;
            end
            PH_STOP:
            begin
                phase_next = PH_STOP;
            end
            default:
            begin
                phase_next = PH_TAG_LO;
            end
        endcase

        if (last_word)
        begin
            phase_next     = PH_TAG_LO;
            tags_seen_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_TAG_LO;
            loops_total_reg   <= '0;
            loop_count_reg    <= '0;
            regs_per_loop_reg <= '0;
            slot_count_reg    <= '0;
            descriptors_reg   <= '0;
            held_low_reg      <= '0;
            tags_seen_reg     <= '0;
            skip_left_reg     <= '0;
            hold_loops_reg    <= '0;
            hold_fmt_reg      <= '0;
            hold_nreg_reg     <= '0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            loops_total_reg   <= loops_total_next;
            loop_count_reg    <= loop_count_next;
            regs_per_loop_reg <= regs_per_loop_next;
            slot_count_reg    <= slot_count_next;
            descriptors_reg   <= descriptors_next;
            held_low_reg      <= held_low_next;
            tags_seen_reg     <= tags_seen_next;
            skip_left_reg     <= skip_left_next;
            hold_loops_reg    <= hold_loops_next;
            hold_fmt_reg      <= hold_fmt_next;
            hold_nreg_reg     <= hold_nreg_next;
        end
    end

endmodule

// ===== rtl/gtrwp_out_buf.sv =====
// ----------------------------------------------------------------------------
// gtrwp_out_buf
// two-entry result queue between the parser and the output channel
// ----------------------------------------------------------------------------
module gtrwp_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  gtrwp_pkg::result_t push_data,
    input  logic               pop,
    output logic               full,
    output logic               out_valid,
    output gtrwp_pkg::result_t out_data
);
    import gtrwp_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/gtrwp_checker.sv =====
// ----------------------------------------------------------------------------
// gtrwp_checker
// port-level checks of the tag register write parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gtrwp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gtrwp_pkg::TDATA_W-1:0] m_tdata,
    input logic [gtrwp_pkg::KIND_W-1:0]  m_tuser,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [2:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata
);
    import gtrwp_pkg::*;

    logic cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TAG_LIMIT);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // a stalled input side means results are queued
    `ASSERT_NOW(a_stall_has_out, clk, rst_n, !s_tready, m_tvalid)
    `ASSERT_NOW(a_kind_legal, clk, rst_n, m_tvalid, m_tuser != 2'd3)
    // limit readback follows the last write
    `ASSERT_NEXT(a_limit_write, clk, rst_n, cfg_wr, prdata[8:0] == $past(pwdata[8:0]))

endmodule

bind gif_tag_register_write_parser_core gtrwp_checker u_gtrwp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
